[hdl/ctb_pkg.sv]
// Shared widths and constants of the centred triangular average band unit.
package ctb_pkg;

  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned BAND_W     = 34;
  localparam int unsigned HALF_W     = 6;
  localparam int unsigned RING_AW    = 7;
  localparam int unsigned RING_DEPTH = 1 << RING_AW;
  localparam int unsigned SUM_W      = 44;
  localparam int unsigned WSUM_W     = 13;

  localparam logic [HALF_W-1:0] DEFAULT_HALF = 6'd56;

  localparam logic signed [BAND_W-1:0] BAND_MAX = {1'b0, {(BAND_W-1){1'b1}}};
  localparam logic signed [BAND_W-1:0] BAND_MIN = {1'b1, {(BAND_W-1){1'b0}}};

endpackage

[hdl/ctb_bar_if.sv]
// Input channel carrying one bar word.
interface ctb_bar_if import ctb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] high;
  logic [PRICE_W-1:0] low;
  logic [PRICE_W-1:0] close;
  logic               last;

  modport source (output valid, high, low, close, last, input ready);
  modport sink   (input valid, high, low, close, last, output ready);
endinterface

[hdl/ctb_res_if.sv]
// Output channel carrying one result word.
interface ctb_res_if import ctb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PRICE_W-1:0]       average;
  logic signed [BAND_W-1:0] upper_band;
  logic signed [BAND_W-1:0] lower_band;
  logic                     band_valid;
  logic                     final_result;

  modport source (output valid, average, upper_band, lower_band, band_valid, final_result,
                  input ready);
  modport sink   (input valid, average, upper_band, lower_band, band_valid, final_result,
                  output ready);
endinterface

[hdl/ctb_cfg_if.sv]
// Configuration write channel carrying the half length word.
interface ctb_cfg_if import ctb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[hdl/centered_tma_variance_bands_unit.sv]
// Centred triangular moving average with asymmetric variance bands.
// Each accepted bar word stores its weighted price (H+L+2C)/4 in a 128-entry ring and
// then produces zero or more result words: a bar's result leaves once H later bars have
// arrived, and a bar flagged last flushes every pending bar and clears the series state.
// The block takes one bar at a time and is not ready while it works. A bar that yields no
// result passes only through acceptance and one emission check. Each result is
// built by one small sequencer around a shared ring read port, a 32x7 multiplier, a
// one-bit-per-cycle divider and a square root unit that settles one root bit per cycle:
// one emission check, a pass over the 2H+1 window slots, the pipeline drain, the average
// division and one step to take the average, then from index H the deviation and, past
// index H, two EMA divisions with a set-up and an update step each and two square roots
// with a set-up and a finishing step each, and finally one output step. The output sits
// in a register, so the next result is computed while the previous word waits to be
// taken; only a word still waiting when the next one is finished stalls the sequencer.
// Bands are zero until the bar index reaches H; at index H both bands equal the average.
module centered_tma_variance_bands_unit import ctb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ctb_bar_if.sink   bar_i,
  ctb_res_if.source res_o,
  ctb_cfg_if.sink   cfg_i
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_WIN       = 4'd2;
  localparam logic [3:0] S_WDRAIN    = 4'd3;
  localparam logic [3:0] S_DIV       = 4'd4;
  localparam logic [3:0] S_AVG_DONE  = 4'd5;
  localparam logic [3:0] S_DIFF      = 4'd6;
  localparam logic [3:0] S_MODE      = 4'd7;
  localparam logic [3:0] S_EMA_SET   = 4'd8;
  localparam logic [3:0] S_EMA_UPD   = 4'd9;
  localparam logic [3:0] S_SQRT_SET  = 4'd10;
  localparam logic [3:0] S_SQRT      = 4'd11;
  localparam logic [3:0] S_SQRT_DONE = 4'd12;
  localparam logic [3:0] S_OUT       = 4'd13;

  // Control state.
  logic [3:0]        state_q, state_d;
  logic [HALF_W-1:0] half_q;
  logic [31:0]       bars_q;
  logic [31:0]       next_q;
  logic              last_q;
  logic [6:0]        slot_q;
  logic [6:0]        cnt_q;
  logic              job_ema_q;
  logic              sel_q;
  logic              rv_q, pv_q, rc_q;
  logic              out_v_q;

  // Datapath state.
  logic [PRICE_W-1:0] ring_q [RING_DEPTH];
  logic [PRICE_W-1:0] ring_rd_q;
  logic [6:0]         rk_q;
  logic [38:0]        prod_q;
  logic [SUM_W-1:0]   sum_q;
  logic [WSUM_W-1:0]  wsum_q;
  logic [31:0]        i_q;
  logic [PRICE_W-1:0] p_q;
  logic [PRICE_W-1:0] avg_q;
  logic               up_q;
  logic [63:0]        d2_q;
  logic [63:0]        vu_q, vd_q;
  logic [63:0]        dvd_q;
  logic [WSUM_W-1:0]  rem_q, div_q;
  logic               ge_q;
  logic [63:0]        root_q, bit_q;
  logic [31:0]        ru_q;
  logic signed [BAND_W-1:0] ub_q, lb_q;
  logic               bv_q, fin_q;
  logic [PRICE_W-1:0]       o_avg_q;
  logic signed [BAND_W-1:0] o_ub_q, o_lb_q;
  logic               o_bv_q, o_fin_q;

  // Combinational helpers.
  logic [HALF_W-1:0]  h_eff;
  logic [6:0]         f_len;
  logic [31:0]        pend;
  logic               emit_go;
  logic               bar_acc;
  logic [PRICE_W+1:0] price_sum;
  logic [5:0]         jj;
  logic [6:0]         js;
  logic               left, center, use_t;
  logic [6:0]         kk;
  logic [RING_AW-1:0] rd_addr;
  logic [WSUM_W:0]    dv_t;
  logic               dv_ge;
  logic [63:0]        sq_sum;
  logic [63:0]        ema_v, ema_t;
  logic               out_free;
  logic [34:0]        x_up, x_dn;

  function automatic logic signed [BAND_W-1:0] band_sat(input logic signed [35:0] s);
    logic signed [BAND_W-1:0] r;
    if (s > 36'(BAND_MAX)) begin
      r = BAND_MAX;
    end else if (s < 36'(BAND_MIN)) begin
      r = BAND_MIN;
    end else begin
      r = s[BAND_W-1:0];
    end
    return r;
  endfunction

  assign h_eff     = (half_q == '0) ? DEFAULT_HALF : half_q;
  assign f_len     = {h_eff, 1'b1};
  assign pend      = bars_q - next_q;
  assign emit_go   = (pend > 32'(h_eff)) || (last_q && (pend != '0));
  assign bar_acc   = bar_i.valid && bar_i.ready;
  assign price_sum = {2'b00, bar_i.high} + {2'b00, bar_i.low} + {1'b0, bar_i.close, 1'b0};
  assign out_free  = !out_v_q || res_o.ready;

  // Window slot: slot 0 is the centre bar, odd slots the older and even slots the newer
  // neighbour at distance j.
  assign js      = slot_q + 7'd1;
  assign jj      = js[6:1];
  assign left    = slot_q[0];
  assign center  = (slot_q == '0);
  assign use_t   = center || (left ? (i_q >= 32'(jj)) : (32'(jj) < pend));
  assign kk      = {1'b0, h_eff} + 7'd1 - {1'b0, jj};
  assign rd_addr = left ? (i_q[RING_AW-1:0] - RING_AW'(jj)) : (i_q[RING_AW-1:0] + RING_AW'(jj));

  // Shared restoring divider step and square root step.
  assign dv_t   = {rem_q, dvd_q[63]};
  assign dv_ge  = dv_t >= {1'b0, div_q};
  assign sq_sum = root_q + bit_q;

  // The EMA side fed by the deviation gets d2, the other side zero.
  assign ema_v = sel_q ? vd_q : vu_q;
  assign ema_t = (sel_q ^ up_q) ? d2_q : '0;

  assign x_up = (({3'b000, ru_q} << 2) + {3'b000, ru_q}) >> 1;
  assign x_dn = (({3'b000, root_q[31:0]} << 2) + {3'b000, root_q[31:0]}) >> 1;

  assign bar_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign res_o.valid        = out_v_q;
  assign res_o.average      = o_avg_q;
  assign res_o.upper_band   = o_ub_q;
  assign res_o.lower_band   = o_lb_q;
  assign res_o.band_valid   = o_bv_q;
  assign res_o.final_result = o_fin_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:      if (bar_acc) state_d = S_CHECK;
      S_CHECK:     state_d = emit_go ? S_WIN : S_IDLE;
      S_WIN:       if (slot_q == {h_eff, 1'b0}) state_d = S_WDRAIN;
      S_WDRAIN:    if (!rv_q && !pv_q) state_d = S_DIV;
      S_DIV:       if (cnt_q == 7'd1) state_d = job_ema_q ? S_EMA_UPD : S_AVG_DONE;
      S_AVG_DONE:  state_d = (i_q >= 32'(h_eff)) ? S_DIFF : S_OUT;
      S_DIFF:      state_d = S_MODE;
      S_MODE:      state_d = (i_q == 32'(h_eff)) ? S_OUT : S_EMA_SET;
      S_EMA_SET:   state_d = S_DIV;
      S_EMA_UPD:   state_d = sel_q ? S_SQRT_SET : S_EMA_SET;
      S_SQRT_SET:  state_d = S_SQRT;
      S_SQRT:      if (cnt_q == 7'd1) state_d = S_SQRT_DONE;
      S_SQRT_DONE: state_d = sel_q ? S_OUT : S_SQRT_SET;
      S_OUT:       if (out_free) state_d = S_CHECK;
      default:     state_d = S_IDLE;
    endcase
  end

  // Ring memory: one write port for arriving bars, one registered read port.
  always_ff @(posedge clk_i) begin
    if (bar_acc) begin
      ring_q[bars_q[RING_AW-1:0]] <= price_sum[PRICE_W+1:2];
    end
    ring_rd_q <= ring_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      half_q    <= DEFAULT_HALF;
      bars_q    <= '0;
      next_q    <= '0;
      last_q    <= 1'b0;
      slot_q    <= '0;
      cnt_q     <= '0;
      job_ema_q <= 1'b0;
      sel_q     <= 1'b0;
      rv_q      <= 1'b0;
      pv_q      <= 1'b0;
      rc_q      <= 1'b0;
      out_v_q   <= 1'b0;
      vu_q      <= '0;
      vd_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        half_q <= cfg_i.data;
      end
      rv_q <= (state_q == S_WIN) && use_t;
      rc_q <= (state_q == S_WIN) && center;
      pv_q <= rv_q;
      // A word taken while the next one is loaded keeps the output valid.
      if (res_o.ready && !((state_q == S_OUT) && out_free)) begin
        out_v_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (bar_acc) begin
            bars_q <= bars_q + 32'd1;
            last_q <= bar_i.last;
          end
        end
        S_CHECK: begin
          slot_q <= '0;
          if (!emit_go && last_q) begin
            bars_q <= '0;
            next_q <= '0;
            last_q <= 1'b0;
            vu_q   <= '0;
            vd_q   <= '0;
          end
        end
        S_WIN: begin
          slot_q <= slot_q + 7'd1;
        end
        S_WDRAIN: begin
          cnt_q     <= 7'd32;
          job_ema_q <= 1'b0;
        end
        S_DIV, S_SQRT: begin
          cnt_q <= cnt_q - 7'd1;
        end
        S_MODE: begin
          sel_q <= 1'b0;
          if (i_q == 32'(h_eff)) begin
            vu_q <= up_q ? d2_q : '0;
            vd_q <= up_q ? '0 : d2_q;
          end
        end
        S_EMA_SET: begin
          cnt_q     <= 7'd64;
          job_ema_q <= 1'b1;
        end
        S_EMA_UPD: begin
          if (sel_q) begin
            vd_q <= ge_q ? (vd_q + dvd_q) : (vd_q - dvd_q);
          end else begin
            vu_q <= ge_q ? (vu_q + dvd_q) : (vu_q - dvd_q);
          end
          sel_q <= !sel_q;
        end
        S_SQRT_SET: begin
          cnt_q <= 7'd32;
        end
        S_SQRT_DONE: begin
          sel_q <= !sel_q;
        end
        S_OUT: begin
          if (out_free) begin
            out_v_q <= 1'b1;
            next_q  <= next_q + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q   <= kk;
    prod_q <= 39'(ring_rd_q) * 39'(rk_q);
    if (rc_q) begin
      p_q <= ring_rd_q;
    end
    if (pv_q) begin
      sum_q <= sum_q + SUM_W'(prod_q);
    end
    case (state_q)
      S_CHECK: begin
        i_q    <= next_q;
        sum_q  <= '0;
        wsum_q <= '0;
        fin_q  <= last_q && (pend == 32'd1);
      end
      S_WIN: begin
        if (use_t) begin
          wsum_q <= wsum_q + WSUM_W'(kk);
        end
      end
      S_WDRAIN: begin
        rem_q <= WSUM_W'(sum_q[SUM_W-1:32]);
        dvd_q <= {sum_q[31:0], 32'd0};
        div_q <= wsum_q;
      end
      S_DIV: begin
        rem_q <= dv_ge ? WSUM_W'(dv_t - {1'b0, div_q}) : dv_t[WSUM_W-1:0];
        dvd_q <= {dvd_q[62:0], dv_ge};
      end
      S_AVG_DONE: begin
        avg_q <= dvd_q[31:0];
        ub_q  <= '0;
        lb_q  <= '0;
        bv_q  <= 1'b0;
      end
      S_DIFF: begin
        up_q <= p_q >= avg_q;
        d2_q <= (p_q >= avg_q) ? (64'(p_q - avg_q) * 64'(p_q - avg_q))
                               : (64'(avg_q - p_q) * 64'(avg_q - p_q));
      end
      S_MODE: begin
        ub_q <= BAND_W'(avg_q);
        lb_q <= BAND_W'(avg_q);
        bv_q <= 1'b1;
      end
      S_EMA_SET: begin
        ge_q  <= ema_t >= ema_v;
        dvd_q <= (ema_t >= ema_v) ? (ema_t - ema_v) : (ema_v - ema_t + 64'(f_len) - 64'd1);
        rem_q <= '0;
        div_q <= WSUM_W'(f_len);
      end
      S_SQRT_SET: begin
        dvd_q  <= sel_q ? vd_q : vu_q;
        root_q <= '0;
        bit_q  <= 64'd1 << 62;
      end
      S_SQRT: begin
        if (dvd_q >= sq_sum) begin
          dvd_q  <= dvd_q - sq_sum;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      S_SQRT_DONE: begin
        if (!sel_q) begin
          ru_q <= root_q[31:0];
        end else begin
          ub_q <= band_sat($signed({4'b0000, avg_q}) + $signed({1'b0, x_up}));
          lb_q <= band_sat($signed({4'b0000, avg_q}) - $signed({1'b0, x_dn}));
        end
      end
      S_OUT: begin
        if (out_free) begin
          o_avg_q <= avg_q;
          o_ub_q  <= ub_q;
          o_lb_q  <= lb_q;
          o_bv_q  <= bv_q;
          o_fin_q <= fin_q;
        end
      end
      default: begin
      end
    endcase
  end

  // A bar leaves results behind only while fewer than H+1 bars wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (bars_q - next_q) <= 32'(h_eff))
    else $error("pending bar count exceeds the half length while idle");

  // The divider remainder must stay below its divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  // An accepted bar is always followed by the emission check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bar_acc |=> (state_q == S_CHECK))
    else $error("accepted bar not followed by emission check");

  // Undefined bands are reported as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !o_bv_q) |-> (o_ub_q == '0) && (o_lb_q == '0))
    else $error("bands nonzero on a result without bands");

endmodule
